FILE: rtl/log_potential_accel_defines.svh
// assertion macros for the logarithmic potential accelerator
// used by the top level only; needs nothing else
`ifndef LOG_POTENTIAL_ACCEL_DEFINES_SVH
`define LOG_POTENTIAL_ACCEL_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define LPA_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is active
`define LPA_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lpa_pkg.sv
// shared types, constants and the log2 fraction table
// no dependencies
`default_nettype none

package lpa_pkg;

	localparam int LOG_TABLE_BITS = 8;
	localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam int CFG_IDX_W = 3;
	localparam int NUM_AXES  = 3;

	// numerator width after dropping eight fraction bits: 95 - 8
	localparam int NUM_W = 87;
	// quotient bits produced by the divider (values up to 2^33-1)
	localparam int Q_W = 33;

	// pipeline latencies in cycles
	localparam int FRONT_LAT = 4;
	localparam int LOG_LAT   = 7;
	localparam int DIV_LAT   = Q_W + 1;
	localparam int POT_DLY   = DIV_LAT - LOG_LAT;
	localparam int PIPE_DEPTH = FRONT_LAT + 1 + DIV_LAT + 1;

	// reset values of the registers
	localparam logic [31:0] SPEED_SQ_RST  = 32'd65536;
	localparam logic [31:0] CORE_SQ_RST   = 32'd0;
	localparam logic [31:0] INV_RATIO_RST = 32'd16777216;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_SQ = 3'd0,
		REG_CORE_SQ  = 3'd1,
		REG_INV_X    = 3'd2,
		REG_INV_Y    = 3'd3,
		REG_INV_Z    = 3'd4
	} cfg_reg_e;

	// lane front results handed to the merge stage
	typedef struct packed {
		logic [63:0]      term;
		logic [NUM_W-1:0] num;
		logic             neg;
	} lane_front_t;

	// divider results per lane
	typedef struct packed {
		logic [Q_W-1:0] q;
		logic           ovf;
		logic           neg;
	} div_res_t;

	// potential path results
	typedef struct packed {
		logic [31:0] pot;
		logic        zero;
	} log_res_t;

	typedef logic [31:0] log_rom_t [TABLE_SIZE];

	// log2(1 + k/2^B) in Q0.32 by repeated squaring
	function automatic log_rom_t build_log_rom();
		log_rom_t    rom;
		logic [63:0] x;
		logic [31:0] frac;
		for (int k = 0; k < TABLE_SIZE; k++) begin
			x = 64'(TABLE_SIZE + k) << (31 - LOG_TABLE_BITS);
			frac = '0;
			for (int i = 0; i < 32; i++) begin
				x = (x * x) >> 31;
				frac = frac << 1;
				if (x >= 64'h1_0000_0000) begin
					frac[0] = 1'b1;
					x = x >> 1;
				end
			end
			rom[k] = frac;
		end
		return rom;
	endfunction

	localparam log_rom_t LOG_ROM = build_log_rom();

	// sign and magnitude to saturated two's complement
	function automatic logic [31:0] pack_signed(input logic neg, input logic [39:0] mag);
		logic [39:0] m;
		if (neg) begin
			m = (mag > 40'h80000000) ? 40'h80000000 : mag;
			return 32'(~m + 40'd1);
		end
		m = (mag > 40'h7fffffff) ? 40'h7fffffff : mag;
		return m[31:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/lpa_lane_front.sv
// one axis lane: weighted square term and acceleration numerator
// depends on lpa_pkg
`default_nettype none

module lpa_lane_front (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic        [31:0] pos,
	input  wire logic        [31:0] inv_ratio,
	input  wire logic        [31:0] speed_sq,
	output lpa_pkg::lane_front_t    res
);

	logic [31:0] mag_s1;
	logic        neg_s1;
	logic [63:0] wa_s2;
	logic [31:0] mag_s2;
	logic        neg_s2;
	logic [63:0] pp_lo_s3;
	logic [62:0] pp_hi_s3;
	logic [63:0] np_lo_s3;
	logic [62:0] np_hi_s3;
	logic        neg_s3;
	logic [94:0] prod;
	logic [94:0] nprod;

	// magnitude and sign
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= pos[31];
			mag_s1 <= pos[31] ? (~pos + 32'd1) : pos;
		end
	end

	// weighted magnitude, below 2^63
	always_ff @(posedge clk) begin
		if (en) begin
			wa_s2  <= inv_ratio * mag_s1;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// partial products for the square term and the numerator
	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s3 <= wa_s2[31:0] * mag_s2;
			pp_hi_s3 <= 63'(wa_s2[62:32] * mag_s2);
			np_lo_s3 <= speed_sq * wa_s2[31:0];
			np_hi_s3 <= 63'(speed_sq * wa_s2[62:32]);
			neg_s3   <= neg_s2;
		end
	end

	assign prod  = {pp_hi_s3[62:0], 32'b0} + {31'b0, pp_lo_s3};
	assign nprod = {np_hi_s3[62:0], 32'b0} + {31'b0, np_lo_s3};

	// term saturated to Q32.32, numerator with eight bits dropped
	always_ff @(posedge clk) begin
		if (en) begin
			res.term <= (|prod[94:88]) ? '1 : prod[87:24];
			res.num  <= nprod[94:8];
			res.neg  <= neg_s3;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lpa_log.sv
// potential path: leading one, table lookup, ln scaling, vq multiply
// depends on lpa_pkg
`default_nettype none

module lpa_log (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic     [63:0] s,
	input  wire logic     [31:0] speed_sq,
	output lpa_pkg::log_res_t    res
);

	localparam int B = lpa_pkg::LOG_TABLE_BITS;

	logic [5:0]   p_c;
	logic [5:0]   p_s6;
	logic [63:0]  s_s6;
	logic         zero_s6;
	logic [63:0]  norm;
	logic [B-1:0] idx_s7;
	logic [5:0]   p_s7;
	logic         zero_s7;
	logic [31:0]  frac;
	logic [5:0]   neg_int;
	logic [37:0]  lmag_s8;
	logic         lneg_s8;
	logic         zero_s8;
	logic [63:0]  lp_lo_s9;
	logic [37:0]  lp_hi_s9;
	logic         lneg_s9;
	logic         zero_s9;
	logic [69:0]  lsum;
	logic [37:0]  ln_s10;
	logic         lneg_s10;
	logic         zero_s10;
	logic [63:0]  vp_lo_s11;
	logic [37:0]  vp_hi_s11;
	logic         lneg_s11;
	logic         zero_s11;
	logic [69:0]  vsum;

	// leading one position
	always_comb begin
		p_c = '0;
		for (int i = 0; i < 64; i++) begin
			if (s[i]) p_c = 6'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s6    <= p_c;
			s_s6    <= s;
			zero_s6 <= (s == 64'd0);
		end
	end

	// normalize and pick the bits below the leading one
	assign norm = s_s6 << (6'd63 - p_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s7  <= norm[62 -: B];
			p_s7    <= p_s6;
			zero_s7 <= zero_s6;
		end
	end

	// log2 magnitude and sign in Q.32
	assign frac    = lpa_pkg::LOG_ROM[idx_s7];
	assign neg_int = 6'd32 - {1'b0, p_s7[4:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			lneg_s8 <= ~p_s7[5];
			lmag_s8 <= p_s7[5] ? {1'b0, p_s7[4:0], frac}
			                   : ({neg_int, 32'b0} - {6'b0, frac});
			zero_s8 <= zero_s7;
		end
	end

	// times ln2
	always_ff @(posedge clk) begin
		if (en) begin
			lp_lo_s9 <= lmag_s8[31:0] * lpa_pkg::LN2_Q32;
			lp_hi_s9 <= 38'(lmag_s8[37:32] * lpa_pkg::LN2_Q32);
			lneg_s9  <= lneg_s8;
			zero_s9  <= zero_s8;
		end
	end

	assign lsum = {lp_hi_s9, 32'b0} + {6'b0, lp_lo_s9};

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s10   <= lsum[69:32];
			lneg_s10 <= lneg_s9;
			zero_s10 <= zero_s9;
		end
	end

	// times vq
	always_ff @(posedge clk) begin
		if (en) begin
			vp_lo_s11 <= speed_sq * ln_s10[31:0];
			vp_hi_s11 <= 38'(speed_sq * ln_s10[37:32]);
			lneg_s11  <= lneg_s10;
			zero_s11  <= zero_s10;
		end
	end

	assign vsum = {vp_hi_s11, 32'b0} + {6'b0, vp_lo_s11};

	// halve and pack
	always_ff @(posedge clk) begin
		if (en) begin
			res.pot  <= lpa_pkg::pack_signed(lneg_s11, {3'b0, vsum[69:33]});
			res.zero <= zero_s11;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lpa_div.sv
// one lane of the acceleration divider, one quotient bit per stage
// depends on lpa_pkg
`default_nettype none

module lpa_div (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [lpa_pkg::NUM_W-1:0]  num,
	input  wire logic                [63:0] s,
	input  wire logic                       neg,
	output lpa_pkg::div_res_t               res
);

	localparam int QW = lpa_pkg::Q_W;
	localparam int NW = lpa_pkg::NUM_W;

	logic [63:0]   rem_q  [QW+1];
	logic [QW-1:0] low_q  [QW+1];
	logic [QW-1:0] quo_q  [QW+1];
	logic [63:0]   div_q  [QW+1];
	logic          ovf_q  [QW+1];
	logic          neg_q  [QW+1];
	logic [63:0]   head;

	assign head = 64'(num[NW-1:QW]);

	// start: upper bits form the first remainder, overflow if quotient needs more bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= head;
			low_q[0] <= num[QW-1:0];
			quo_q[0] <= '0;
			div_q[0] <= s;
			ovf_q[0] <= (head >= s);
			neg_q[0] <= neg;
		end
	end

	// restoring steps
	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [64:0] pre;
		logic [64:0] diff;
		logic        ge;

		assign pre  = {rem_q[k-1], low_q[k-1][QW-1]};
		assign diff = pre - {1'b0, div_q[k-1]};
		assign ge   = (pre >= {1'b0, div_q[k-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[63:0] : pre[63:0];
				low_q[k] <= low_q[k-1] << 1;
				quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
				div_q[k] <= div_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
				neg_q[k] <= neg_q[k-1];
			end
		end
	end

	assign res.q   = quo_q[QW];
	assign res.ovf = ovf_q[QW];
	assign res.neg = neg_q[QW];

endmodule

`default_nettype wire

FILE: rtl/log_potential_accel.sv
// top level: config registers, three axis lanes, merge, potential path, dividers
// depends on lpa_pkg, lpa_lane_front, lpa_log, lpa_div, log_potential_accel_defines.svh
//
// channel   direction  payload
// s_axis    in         tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64]
// m_axis    out        tdata: potential, acc_x, acc_y, acc_z; tuser: invalid
// cfg       in         cfg_we, cfg_idx, cfg_data (write only)
//
// one item per cycle while no output item waits; 40 register stages lie between
// an accepted item and its result
// latency is set by the 33-step restoring divider in each lane
// the whole pipeline advances together and holds while the output item waits
// arst_n clears the valid bits and reloads the registers
`default_nettype none
`include "log_potential_accel_defines.svh"

module log_potential_accel (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	input  wire logic                     [95:0] s_tdata,  // pos_x, pos_y, pos_z
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	output      logic                    [127:0] m_tdata,  // potential, acc_x, acc_y, acc_z
	output      logic                      [0:0] m_tuser,  // invalid
	input  wire logic                            cfg_we,
	input  wire logic [lpa_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic                     [31:0] cfg_data
);

	localparam int NA = lpa_pkg::NUM_AXES;
	localparam int PD = lpa_pkg::PIPE_DEPTH;
	localparam int QW = lpa_pkg::Q_W;
	localparam int POT_DLY_N = lpa_pkg::POT_DLY;

	logic [31:0] speed_sq_q;
	logic [31:0] core_sq_q;
	logic [31:0] inv_ratio_q [NA];
	logic [PD:1] v_q;
	logic        en;

	lpa_pkg::lane_front_t front    [NA];
	lpa_pkg::lane_front_t front_s5 [NA];
	lpa_pkg::div_res_t    dres     [NA];
	lpa_pkg::log_res_t    lres;
	lpa_pkg::log_res_t    ldly_q   [POT_DLY_N];
	logic [65:0]          ssum;
	logic [63:0]          s_s5;
	logic [31:0]          acc      [NA];

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_sq_q <= lpa_pkg::SPEED_SQ_RST;
			core_sq_q  <= lpa_pkg::CORE_SQ_RST;
			for (int i = 0; i < NA; i++) inv_ratio_q[i] <= lpa_pkg::INV_RATIO_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				lpa_pkg::REG_SPEED_SQ: speed_sq_q     <= cfg_data;
				lpa_pkg::REG_CORE_SQ:  core_sq_q      <= cfg_data;
				lpa_pkg::REG_INV_X:    inv_ratio_q[0] <= cfg_data;
				lpa_pkg::REG_INV_Y:    inv_ratio_q[1] <= cfg_data;
				lpa_pkg::REG_INV_Z:    inv_ratio_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advance and valid bits
	assign en       = ~v_q[PD] | m_tready;
	assign s_tready = en;
	assign m_tvalid = v_q[PD];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[PD-1:1], s_tvalid};
		end
	end

	// axis lanes
	for (genvar j = 0; j < NA; j++) begin : g_lane
		lpa_lane_front u_front (
			.clk       (clk),
			.en        (en),
			.pos       (s_tdata[32*j +: 32]),
			.inv_ratio (inv_ratio_q[j]),
			.speed_sq  (speed_sq_q),
			.res       (front[j])
		);

		lpa_div u_div (
			.clk (clk),
			.en  (en),
			.num (front_s5[j].num),
			.s   (s_s5),
			.neg (front_s5[j].neg),
			.res (dres[j])
		);

		assign acc[j] = lpa_pkg::pack_signed(~dres[j].neg,
			dres[j].ovf ? 40'h1_0000_0000 : {{(40-QW){1'b0}}, dres[j].q});
	end

	// merge: saturating inner sum
	assign ssum = {18'b0, core_sq_q, 16'b0} + {2'b0, front[0].term}
	            + {2'b0, front[1].term} + {2'b0, front[2].term};

	always_ff @(posedge clk) begin
		if (en) begin
			s_s5 <= (|ssum[65:64]) ? '1 : ssum[63:0];
			for (int i = 0; i < NA; i++) front_s5[i] <= front[i];
		end
	end

	lpa_log u_log (
		.clk      (clk),
		.en       (en),
		.s        (s_s5),
		.speed_sq (speed_sq_q),
		.res      (lres)
	);

	// align the potential with the divider outputs
	always_ff @(posedge clk) begin
		if (en) begin
			ldly_q[0] <= lres;
			for (int i = 1; i < POT_DLY_N; i++) ldly_q[i] <= ldly_q[i-1];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser[0] <= ldly_q[POT_DLY_N-1].zero;
			m_tdata    <= ldly_q[POT_DLY_N-1].zero ? '0
			            : {acc[2], acc[1], acc[0], ldly_q[POT_DLY_N-1].pot};
		end
	end

	// checks
	`LPA_ASSERT_NOW(a_invalid_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == 128'd0, "invalid item carries nonzero data")
	`LPA_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, $stable(v_q), "pipeline moved during output stall")

endmodule

`default_nettype wire

FILE: sim/tb_log_potential_accel.sv
// testbench for the logarithmic potential accelerator: directed, backpressure and random items
// predicts each result with a local fixed-point model; depends on lpa_pkg and the rtl
`timescale 1ns / 100ps

module tb_log_potential_accel;

	localparam int WDOG_LIMIT = 20000;
	localparam int LTB = lpa_pkg::LOG_TABLE_BITS;
	localparam int TSZ = lpa_pkg::TABLE_SIZE;

	typedef struct packed {
		logic [31:0] pot;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
		logic        inv;
	} accel_res_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic   [95:0] s_tdata;
	logic          m_tvalid;
	logic          m_tready;
	logic  [127:0] m_tdata;
	logic    [0:0] m_tuser;
	logic          cfg_we;
	logic [lpa_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic   [31:0] cfg_data;

	// predictor copy of the registers and log table
	logic [31:0] m_speed;
	logic [31:0] m_core;
	logic [31:0] m_ratio [3];
	logic [31:0] m_rom [TSZ];

	accel_res_t  expected_q [$];
	int          fail_cnt;
	int          idle_cnt;
	bit          rx_idle;
	bit          hold_rx;
	bit          quiet;

	log_potential_accel DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// log2 fraction table by repeated squaring
	task automatic fill_rom();
		logic [63:0] x;
		logic [31:0] f;
		for (int k = 0; k < TSZ; k++) begin
			x = 64'(TSZ + k) << (31 - LTB);
			f = '0;
			for (int i = 0; i < 32; i++) begin
				x = (x * x) >> 31;
				f = f << 1;
				if (x >= 64'h1_0000_0000) begin
					f[0] = 1'b1;
					x = x >> 1;
				end
			end
			m_rom[k] = f;
		end
	endtask

	function automatic logic [31:0] sat_field(logic neg, logic [127:0] mag);
		if (neg) begin
			if (mag > 128'h80000000) mag = 128'h80000000;
			return 32'(-mag);
		end
		if (mag > 128'h7fffffff) mag = 128'h7fffffff;
		return mag[31:0];
	endfunction

	function automatic logic [63:0] sat64(logic [127:0] v);
		return (v[127:64] != 0) ? 64'hffff_ffff_ffff_ffff : v[63:0];
	endfunction

	function automatic accel_res_t predict_accel(logic [95:0] pos);
		accel_res_t  r;
		logic [31:0] v;
		logic [63:0] mag [3];
		logic [63:0] wa [3];
		logic        neg [3];
		logic [64:0] s;
		logic [63:0] s64, lmag, lnv, pmag;
		logic [127:0] q;
		logic signed [65:0] lval;
		int          p;
		logic [LTB-1:0] idx;
		s = 65'(m_core) << 16;
		for (int j = 0; j < 3; j++) begin
			v = pos[32*j +: 32];
			neg[j] = v[31];
			mag[j] = v[31] ? (64'h1_0000_0000 - 64'(v)) : 64'(v);
			wa[j] = 64'(m_ratio[j]) * mag[j];
			s = s + 65'(sat64((128'(wa[j]) * 128'(mag[j])) >> 24));
			if (s[64]) s = 65'h0_ffff_ffff_ffff_ffff;
		end
		s64 = s[63:0];
		r = '0;
		if (s64 == 0) begin
			r.inv = 1'b1;
			return r;
		end
		p = 63;
		while (!s64[p]) p--;
		idx = LTB'((s64 << (63 - p)) >> (63 - LTB));
		lval = (66'(p) - 66'sd32) * 66'sd4294967296 + 66'(m_rom[idx]);
		lmag = (lval < 0) ? 64'(-lval) : 64'(lval);
		lnv = sat64((128'(lmag) * 128'(lpa_pkg::LN2_Q32)) >> 32);
		pmag = sat64((128'(m_speed) * 128'(lnv)) >> 33);
		r.pot = sat_field(lval < 0, 128'(pmag));
		for (int j = 0; j < 3; j++) begin
			q = (128'(m_speed) * 128'(wa[j])) / 128'(s64);
			if (q > (128'd1 << 40)) q = 128'd1 << 40;
			q = q >> 8;
			v = (q == 0) ? 32'd0 : sat_field(!neg[j], q);
			if (j == 0) r.ax = v;
			else if (j == 1) r.ay = v;
			else r.az = v;
		end
		return r;
	endfunction

	// one item; waits for acceptance, valid stays up for a following item
	task automatic send_pos(logic [95:0] pos, bit gaps);
		if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pos;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_q.push_back(predict_accel(pos));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (lpa_pkg::PIPE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic write_reg(lpa_pkg::cfg_reg_e idx, logic [31:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lpa_pkg::REG_SPEED_SQ: m_speed <= val;
			lpa_pkg::REG_CORE_SQ:  m_core <= val;
			lpa_pkg::REG_INV_X:    m_ratio[0] <= val;
			lpa_pkg::REG_INV_Y:    m_ratio[1] <= val;
			lpa_pkg::REG_INV_Z:    m_ratio[2] <= val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_regs(logic [31:0] vq, logic [31:0] rc, logic [31:0] qx,
			logic [31:0] qy, logic [31:0] qz);
		drain_results();
		write_reg(lpa_pkg::REG_SPEED_SQ, vq);
		write_reg(lpa_pkg::REG_CORE_SQ, rc);
		write_reg(lpa_pkg::REG_INV_X, qx);
		write_reg(lpa_pkg::REG_INV_Y, qy);
		write_reg(lpa_pkg::REG_INV_Z, qz);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
			2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			3: return 32'd0;
			default: return 32'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
		endcase
	endfunction

	function automatic logic [31:0] rand_reg();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
			2: return $urandom_range(1, 32'h3ffff);
			default: return $urandom_range(32'h0020_0000, 32'h0400_0000);
		endcase
	endfunction

	// extremes of position, zero sum, saturation, zero coordinate
	task automatic test_directed();
		logic [31:0] c [6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h0001_0000};
		send_pos(96'h0, 0);
		for (int i = 0; i < 6; i++) send_pos({c[i], c[5 - i], c[(i + 2) % 6]}, 0);
		send_pos({32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0);
		send_pos({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 0);
		send_pos({32'h0, 32'h0, 32'h0001_0000}, 0);
		set_regs(32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_pos({32'hffff_ffff, 32'h0, 32'h1}, 0);
		send_pos({32'h8000_0000, 32'h7fff_ffff, 32'h0}, 0);
		send_pos({32'h0, 32'h0, 32'h0}, 0);
		set_regs(32'h0001_0000, 32'hffff_ffff, 32'h0, 32'h0, 32'h0);
		send_pos({32'h1234_5678, 32'h8765_4321, 32'h1}, 0);
		set_regs(32'h0, 32'h1, 32'h0100_0000, 32'h0, 32'h0200_0000);
		send_pos({32'h0, 32'h0, 32'h0}, 0);
		send_pos({32'h0001_0000, 32'hffff_0000, 32'h0}, 0);
	endtask

	// receiver holds off for a counted stretch while items keep coming
	task automatic test_backpressure();
		fork
			begin
				hold_rx = 1'b1;
				repeat (200) @(posedge clk);
				hold_rx = 1'b0;
			end
			for (int i = 0; i < 80; i++)
				send_pos({rand_coord(), rand_coord(), rand_coord()}, 0);
		join
		drain_results();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			set_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
			for (int i = 0; i < 150; i++)
				send_pos({rand_coord(), rand_coord(), rand_coord()}, 1);
		end
		drain_results();
		set_regs(lpa_pkg::SPEED_SQ_RST, lpa_pkg::CORE_SQ_RST, lpa_pkg::INV_RATIO_RST,
			lpa_pkg::INV_RATIO_RST, lpa_pkg::INV_RATIO_RST);
		quiet = 1'b1;
		for (int i = 0; i < 50; i++)
			send_pos({rand_coord(), rand_coord(), rand_coord()}, 1);
	endtask

	// receiver idling
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_rx) begin
			m_tready <= 1'b0;
		end else if (quiet) begin
			m_tready <= 1'b1;
		end else if (rx_idle) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		rx_idle = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 7) == 0) begin
				rx_idle = 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				rx_idle = 1'b0;
			end
		end
	end

	// check each result against the oldest prediction
	always @(posedge clk) begin
		accel_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("result with no prediction waiting");
				fail_cnt++;
			end else begin
				e = expected_q.pop_front();
				if (m_tdata[31:0] !== e.pot) begin
					$error("potential expected %h actual %h", e.pot, m_tdata[31:0]);
					fail_cnt++;
				end
				if (m_tdata[63:32] !== e.ax) begin
					$error("acc_x expected %h actual %h", e.ax, m_tdata[63:32]);
					fail_cnt++;
				end
				if (m_tdata[95:64] !== e.ay) begin
					$error("acc_y expected %h actual %h", e.ay, m_tdata[95:64]);
					fail_cnt++;
				end
				if (m_tdata[127:96] !== e.az) begin
					$error("acc_z expected %h actual %h", e.az, m_tdata[127:96]);
					fail_cnt++;
				end
				if (m_tuser[0] !== e.inv) begin
					$error("invalid expected %b actual %b", e.inv, m_tuser[0]);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake and no config write
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cnt <= 0;
		end else if (idle_cnt >= WDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	initial begin
		fail_cnt = 0;
		idle_cnt = 0;
		hold_rx = 1'b0;
		quiet = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_idx = lpa_pkg::REG_SPEED_SQ;
		cfg_data = '0;
		m_speed = lpa_pkg::SPEED_SQ_RST;
		m_core = lpa_pkg::CORE_SQ_RST;
		for (int j = 0; j < 3; j++) m_ratio[j] = lpa_pkg::INV_RATIO_RST;
		fill_rom();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain_results();
		test_backpressure();
		test_random();
		drain_results();
		if (fail_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
